FILE: rtl/core/rrd_pkg.sv
`timescale 1ns / 1ps
package rrd_pkg;

    localparam int C_PROD_FRAC  = 28;
    localparam int C_TOL_W      = 29;
    localparam int C_DIV_STEPS  = 35;
    localparam int C_SQRT_STEPS = 32;
    localparam int C_LANES      = 4;

    localparam logic [C_TOL_W-1:0] C_TOL_RESET = 29'd268;
    localparam logic [34:0]        C_OFF_LIMIT = 35'h4_0000_0000;

    typedef struct packed {
        logic signed [31:0] origin0_x;
        logic signed [31:0] origin0_y;
        logic signed [15:0] dir0_x;
        logic signed [15:0] dir0_y;
        logic signed [31:0] origin1_x;
        logic signed [31:0] origin1_y;
        logic signed [15:0] dir1_x;
        logic signed [15:0] dir1_y;
    } t_ray_in;

    typedef struct packed {
        logic        [63:0] squared_distance;
        logic        [31:0] distance;
        logic signed [31:0] near0_x;
        logic signed [31:0] near0_y;
        logic signed [31:0] near1_x;
        logic signed [31:0] near1_y;
        logic               rays_parallel;
    } t_ray_out;

    typedef struct packed {
        logic [34:0] rem;
        logic [34:0] dvd;
        logic [34:0] quo;
        logic        ovf;
        logic        neg;
    } t_div_lane;

    typedef struct packed {
        logic                           valid;
        logic [34:0]                    den;
        t_div_lane [C_LANES-1:0]        lane;
        logic [C_LANES-1:0][31:0]       org;
        logic [63:0]                    sq;
        logic                           par;
    } t_div_beat;

    typedef struct packed {
        logic                           valid;
        logic [63:0]                    rad;
        logic [33:0]                    rem;
        logic [31:0]                    root;
        logic [C_LANES-1:0][31:0]       near;
        logic [63:0]                    sq;
        logic                           par;
    } t_sqrt_beat;

endpackage

FILE: rtl/core/rrd_front.sv
`timescale 1ns / 1ps
module rrd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rrd_pkg::t_ray_in              i_item,
    input  logic [rrd_pkg::C_TOL_W-1:0]   i_tol,
    output rrd_pkg::t_div_beat            o_beat
);
    import rrd_pkg::*;

    function automatic logic [63:0] f_side_sq(logic [65:0] c, logic [71:0] q);
        logic [72:0] cx;
        logic [72:0] d;
        begin
            cx = {7'b0, c};
            d  = (cx >= {1'b0, q}) ? cx - {1'b0, q} : {1'b0, q} - cx;
            return (|d[72:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : d[63:0];
        end
    endfunction

    // stage 1: origin difference
    logic               r1_v;
    t_ray_in            r1_in;
    logic signed [32:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_valid;
        r1_in <= i_item;
        r1_dx <= 33'(i_item.origin0_x) - 33'(i_item.origin1_x);
        r1_dy <= 33'(i_item.origin0_y) - 33'(i_item.origin1_y);
    end

    // stage 2: dot product terms
    logic               r2_v;
    t_ray_in            r2_in;
    logic signed [48:0] r2_dx0, r2_dy0, r2_dx1, r2_dy1;
    logic signed [31:0] r2_ddx, r2_ddy;
    logic signed [65:0] r2_dxx, r2_dyy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_in  <= r1_in;
        r2_dx0 <= r1_dx * 49'(r1_in.dir0_x);
        r2_dy0 <= r1_dy * 49'(r1_in.dir0_y);
        r2_dx1 <= r1_dx * 49'(r1_in.dir1_x);
        r2_dy1 <= r1_dy * 49'(r1_in.dir1_y);
        r2_ddx <= r1_in.dir0_x * r1_in.dir1_x;
        r2_ddy <= r1_in.dir0_y * r1_in.dir1_y;
        r2_dxx <= r1_dx * r1_dx;
        r2_dyy <= r1_dy * r1_dy;
    end

    // stage 3: a01, b0, b1, c
    logic               r3_v;
    t_ray_in            r3_in;
    logic signed [32:0] r3_a01;
    logic signed [49:0] r3_b0, r3_b1;
    logic [65:0]        r3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_in  <= r2_in;
        r3_a01 <= -(33'(r2_ddx) + 33'(r2_ddy));
        r3_b0  <= 50'(r2_dx0) + 50'(r2_dy0);
        r3_b1  <= -(50'(r2_dx1) + 50'(r2_dy1));
        r3_c   <= $unsigned(r2_dxx) + $unsigned(r2_dyy);
    end

    // stage 4: split products
    logic [31:0]        w_am;
    logic [49:0]        w_bm0, w_bm1;

    assign w_am  = r3_a01[32] ? 32'(-r3_a01) : 32'(r3_a01);
    assign w_bm0 = r3_b0[49] ? 50'(-r3_b0) : 50'(r3_b0);
    assign w_bm1 = r3_b1[49] ? 50'(-r3_b1) : 50'(r3_b1);

    logic               r4_v;
    t_ray_in            r4_in;
    logic [63:0]        r4_asq;
    logic signed [57:0] r4_ab1h, r4_ab0h;
    logic signed [58:0] r4_ab1l, r4_ab0l;
    logic [49:0]        r4_s0hh, r4_s0hl, r4_s0ll, r4_s1hh, r4_s1hl, r4_s1ll;
    logic signed [32:0] r4_a01;
    logic signed [49:0] r4_b0, r4_b1;
    logic [65:0]        r4_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_in   <= r3_in;
        r4_asq  <= w_am * w_am;
        r4_ab1h <= 58'(r3_a01) * 58'($signed(r3_b1[49:25]));
        r4_ab1l <= 59'(r3_a01) * 59'($signed({1'b0, r3_b1[24:0]}));
        r4_ab0h <= 58'(r3_a01) * 58'($signed(r3_b0[49:25]));
        r4_ab0l <= 59'(r3_a01) * 59'($signed({1'b0, r3_b0[24:0]}));
        r4_s0hh <= 50'(w_bm0[49:25]) * 50'(w_bm0[49:25]);
        r4_s0hl <= 50'(w_bm0[49:25]) * 50'(w_bm0[24:0]);
        r4_s0ll <= 50'(w_bm0[24:0]) * 50'(w_bm0[24:0]);
        r4_s1hh <= 50'(w_bm1[49:25]) * 50'(w_bm1[49:25]);
        r4_s1hl <= 50'(w_bm1[49:25]) * 50'(w_bm1[24:0]);
        r4_s1ll <= 50'(w_bm1[24:0]) * 50'(w_bm1[24:0]);
        r4_a01  <= r3_a01;
        r4_b0   <= r3_b0;
        r4_b1   <= r3_b1;
        r4_c    <= r3_c;
    end

    // stage 5: determinant, region numerators, squared parameters
    logic [35:0]        w_asq, w_one;
    logic [34:0]        w_det;
    logic [99:0]        w_bsq0, w_bsq1;

    assign w_one  = 36'(1) << C_PROD_FRAC;
    assign w_asq  = 36'(r4_asq >> C_PROD_FRAC);
    assign w_det  = (w_one >= w_asq) ? 35'(w_one - w_asq) : 35'(w_asq - w_one);
    assign w_bsq0 = (100'(r4_s0hh) << 50) + (100'(r4_s0hl) << 26) + 100'(r4_s0ll);
    assign w_bsq1 = (100'(r4_s1hh) << 50) + (100'(r4_s1hl) << 26) + 100'(r4_s1ll);

    logic               r5_v;
    t_ray_in            r5_in;
    logic signed [84:0] r5_n0, r5_n1;
    logic [34:0]        r5_det;
    logic               r5_par, r5_apos;
    logic [71:0]        r5_q0, r5_q1;
    logic signed [49:0] r5_b0, r5_b1;
    logic [65:0]        r5_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        r5_in   <= r4_in;
        r5_n0   <= (85'(r4_ab1h) <<< 25) + 85'(r4_ab1l) - (85'(r4_b0) <<< C_PROD_FRAC);
        r5_n1   <= (85'(r4_ab0h) <<< 25) + 85'(r4_ab0l) - (85'(r4_b1) <<< C_PROD_FRAC);
        r5_det  <= w_det;
        r5_par  <= (w_det == 35'd0) || (w_det < 35'(i_tol));
        r5_apos <= !r4_a01[32] && (r4_a01 != 33'sd0);
        r5_q0   <= 72'(w_bsq0 >> C_PROD_FRAC);
        r5_q1   <= 72'(w_bsq1 >> C_PROD_FRAC);
        r5_b0   <= r4_b0;
        r5_b1   <= r4_b1;
        r5_c    <= r4_c;
    end

    // stage 6: region choice
    logic        n_n0neg, n_n1neg;
    logic [84:0] n_n0mag, n_n1mag;
    logic [34:0] n_den;
    logic [63:0] n_sq;
    logic        w_b0neg, w_b1neg;
    logic [84:0] w_side0mag, w_side1mag;
    logic        w_side0neg, w_side1neg;

    assign w_b0neg    = r5_b0[49];
    assign w_b1neg    = r5_b1[49];
    assign w_side0neg = !w_b0neg && (r5_b0 != 50'sd0);
    assign w_side1neg = !w_b1neg && (r5_b1 != 50'sd0);
    assign w_side0mag = 85'(w_b0neg ? 50'(-r5_b0) : 50'(r5_b0));
    assign w_side1mag = 85'(w_b1neg ? 50'(-r5_b1) : 50'(r5_b1));

    always_comb begin
        logic side0, side1;
        side0   = 1'b0;
        side1   = 1'b0;
        n_n0neg = 1'b0;
        n_n0mag = '0;
        n_n1neg = 1'b0;
        n_n1mag = '0;
        n_den   = 35'd1;
        n_sq    = (|r5_c[65:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : r5_c[63:0];
        if (!r5_par) begin
            if (!r5_n0[84] && !r5_n1[84]) begin
                n_n0mag = $unsigned(r5_n0);
                n_n1mag = $unsigned(r5_n1);
                n_den   = r5_det;
                n_sq    = '0;
            end else if (!r5_n0[84] || (r5_n1[84] && w_b0neg)) begin
                side0 = w_b0neg;
            end else begin
                side1 = w_b1neg;
            end
        end else if (r5_apos) begin
            side0 = w_b0neg;
        end else if (!w_b0neg) begin
            side1 = 1'b1;
        end else begin
            side0 = 1'b1;
        end
        if (side0) begin
            n_n0neg = w_side0neg;
            n_n0mag = w_side0mag;
            n_sq    = f_side_sq(r5_c, r5_q0);
        end
        if (side1) begin
            n_n1neg = w_side1neg;
            n_n1mag = w_side1mag;
            n_sq    = f_side_sq(r5_c, r5_q1);
        end
    end

    logic        r6_v;
    t_ray_in     r6_in;
    logic        r6_n0neg, r6_n1neg;
    logic [84:0] r6_n0mag, r6_n1mag;
    logic [34:0] r6_den;
    logic [63:0] r6_sq;
    logic        r6_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= r5_v;
        r6_in    <= r5_in;
        r6_n0neg <= n_n0neg;
        r6_n0mag <= n_n0mag;
        r6_n1neg <= n_n1neg;
        r6_n1mag <= n_n1mag;
        r6_den   <= n_den;
        r6_sq    <= n_sq;
        r6_par   <= r5_par;
    end

    // stage 7: numerator times direction, three partial products per lane
    logic [C_LANES-1:0][15:0] w_dir;
    logic [C_LANES-1:0][31:0] w_org;

    assign w_dir = {r6_in.dir1_y, r6_in.dir1_x, r6_in.dir0_y, r6_in.dir0_x};
    assign w_org = {r6_in.origin1_y, r6_in.origin1_x, r6_in.origin0_y, r6_in.origin0_x};

    logic                     r7_v;
    logic [44:0]              r7_pp [C_LANES][3];
    logic [C_LANES-1:0]       r7_neg;
    logic [C_LANES-1:0][31:0] r7_org;
    logic [34:0]              r7_den;
    logic [63:0]              r7_sq;
    logic                     r7_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else          r7_v <= r6_v;
        for (int l = 0; l < C_LANES; l++) begin
            logic [86:0] m;
            logic [15:0] dm;
            m  = (l < 2) ? {2'b0, r6_n0mag} : {2'b0, r6_n1mag};
            dm = w_dir[l][15] ? 16'(-w_dir[l]) : w_dir[l];
            for (int k = 0; k < 3; k++) begin
                r7_pp[l][k] <= 45'(m[29*k +: 29]) * 45'(dm);
            end
            r7_neg[l] <= ((l < 2) ? r6_n0neg : r6_n1neg) ^ w_dir[l][15];
        end
        r7_org <= w_org;
        r7_den <= r6_den;
        r7_sq  <= r6_sq;
        r7_par <= r6_par;
    end

    // stage 8: scale and set up the divider
    t_div_beat n_beat, r_beat;

    always_comb begin
        n_beat       = '0;
        n_beat.valid = r7_v;
        n_beat.den   = r7_den;
        n_beat.org   = r7_org;
        n_beat.sq    = r7_sq;
        n_beat.par   = r7_par;
        for (int l = 0; l < C_LANES; l++) begin
            logic [102:0] s;
            logic [74:0]  p;
            s = 103'(r7_pp[l][0]) + (103'(r7_pp[l][1]) << 29) + (103'(r7_pp[l][2]) << 58);
            p = 75'(s >> C_PROD_FRAC);
            n_beat.lane[l].ovf = p[74:35] >= 40'(r7_den);
            n_beat.lane[l].rem = p[69:35];
            n_beat.lane[l].dvd = p[34:0];
            n_beat.lane[l].quo = '0;
            n_beat.lane[l].neg = r7_neg[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_beat.valid <= 1'b0;
        else          r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

FILE: rtl/core/rrd_div_cell.sv
`timescale 1ns / 1ps
module rrd_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrd_pkg::t_div_beat i_beat,
    output rrd_pkg::t_div_beat o_beat
);
    import rrd_pkg::*;

    t_div_beat n_beat, r_beat;

    // one quotient bit per lane
    always_comb begin
        n_beat = i_beat;
        for (int l = 0; l < C_LANES; l++) begin
            logic [35:0] t;
            logic        ge;
            t  = {i_beat.lane[l].rem, i_beat.lane[l].dvd[34]};
            ge = t >= {1'b0, i_beat.den};
            n_beat.lane[l].rem = ge ? 35'(t - {1'b0, i_beat.den}) : 35'(t);
            n_beat.lane[l].quo = {i_beat.lane[l].quo[33:0], ge};
            n_beat.lane[l].dvd = {i_beat.lane[l].dvd[33:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_beat.valid <= 1'b0;
        else          r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

FILE: rtl/core/rrd_sqrt_cell.sv
`timescale 1ns / 1ps
module rrd_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrd_pkg::t_sqrt_beat i_beat,
    output rrd_pkg::t_sqrt_beat o_beat
);
    import rrd_pkg::*;

    t_sqrt_beat  n_beat, r_beat;
    logic [35:0] w_t, w_trial;
    logic        w_ge;

    // one root bit per cell
    assign w_t     = {i_beat.rem, i_beat.rad[63:62]};
    assign w_trial = {2'b0, i_beat.root, 2'b01};
    assign w_ge    = w_t >= w_trial;

    always_comb begin
        n_beat      = i_beat;
        n_beat.rem  = w_ge ? 34'(w_t - w_trial) : 34'(w_t);
        n_beat.root = {i_beat.root[30:0], w_ge};
        n_beat.rad  = {i_beat.rad[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_beat.valid <= 1'b0;
        else          r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

FILE: rtl/core/ray_ray_distance_2d.sv
`timescale 1ns / 1ps
// Distance between two 2D rays in fixed point.
// Input: a beat is taken when start is high and busy is low. busy never
// rises, so a new ray pair can be issued on every clock.
// Output: each result is shown on o_result for one cycle with o_done high,
// in input order. The receiver cannot stall the block and does not need to.
// Throughput: one pair per cycle. The pipeline holds the 8 arithmetic stages,
// the 35-cell restoring divider chain that scales the closest points, one
// point saturation stage and the 32-cell square-root chain.
// Config: the parallel tolerance is written on the cfg channel (o_cfg_ready
// is always high); write it only while no results are outstanding.
// Reset: synchronous active low; clears all in-flight beats and sets
// the parallel tolerance to 268.
module ray_ray_distance_2d (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rrd_pkg::t_ray_in            i_item,
    output logic                        o_done,
    output rrd_pkg::t_ray_out           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rrd_pkg::C_TOL_W-1:0] i_cfg_data
);
    import rrd_pkg::*;

    logic [C_TOL_W-1:0] r_tol;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_tol <= C_TOL_RESET;
        else if (i_cfg_valid) r_tol <= i_cfg_data;
    end

    t_div_beat  w_div [C_DIV_STEPS+1];
    t_sqrt_beat w_sq  [C_SQRT_STEPS+1];

    rrd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_tol   (r_tol),
        .o_beat  (w_div[0])
    );

    for (genvar k = 0; k < C_DIV_STEPS; k++) begin : g_div
        rrd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_div[k]),
            .o_beat  (w_div[k+1])
        );
    end

    // point offset saturation
    t_sqrt_beat n_pt, r_pt;

    always_comb begin
        n_pt       = '0;
        n_pt.valid = w_div[C_DIV_STEPS].valid;
        n_pt.rad   = w_div[C_DIV_STEPS].sq;
        n_pt.sq    = w_div[C_DIV_STEPS].sq;
        n_pt.par   = w_div[C_DIV_STEPS].par;
        for (int l = 0; l < C_LANES; l++) begin
            logic [34:0]        off;
            logic signed [36:0] o37, s;
            off = (w_div[C_DIV_STEPS].lane[l].ovf ||
                   w_div[C_DIV_STEPS].lane[l].quo > C_OFF_LIMIT) ?
                  C_OFF_LIMIT : w_div[C_DIV_STEPS].lane[l].quo;
            o37 = 37'($signed(w_div[C_DIV_STEPS].org[l]));
            s   = w_div[C_DIV_STEPS].lane[l].neg ? o37 - $signed({2'b0, off})
                                                 : o37 + $signed({2'b0, off});
            if (s > 37'sd2147483647)       n_pt.near[l] = 32'h7FFF_FFFF;
            else if (s < -37'sd2147483648) n_pt.near[l] = 32'h8000_0000;
            else                           n_pt.near[l] = s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pt.valid <= 1'b0;
        else          r_pt <= n_pt;
    end

    assign w_sq[0] = r_pt;

    for (genvar k = 0; k < C_SQRT_STEPS; k++) begin : g_sqrt
        rrd_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_sq[k]),
            .o_beat  (w_sq[k+1])
        );
    end

    assign o_done = w_sq[C_SQRT_STEPS].valid;

    always_comb begin
        o_result.squared_distance = w_sq[C_SQRT_STEPS].sq;
        o_result.distance         = w_sq[C_SQRT_STEPS].root;
        o_result.near0_x          = w_sq[C_SQRT_STEPS].near[0];
        o_result.near0_y          = w_sq[C_SQRT_STEPS].near[1];
        o_result.near1_x          = w_sq[C_SQRT_STEPS].near[2];
        o_result.near1_y          = w_sq[C_SQRT_STEPS].near[3];
        o_result.rays_parallel    = w_sq[C_SQRT_STEPS].par;
    end

endmodule
